@@ sv/assert_macros.svh @@
// Assertion macros shared by the az/el to X-Y mount RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with synchronous reset masking.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ sv/azel_pkg.sv @@
// Shared constants, types and functions of the az/el to X-Y mount converter.
package azel_pkg;

   // Pipeline sizing
   localparam int CORDIC_STAGES = 16;
   localparam int DATA_WIDTH    = 18;
   localparam int FRAC          = DATA_WIDTH - 2;
   localparam int XW            = DATA_WIDTH + 1;   // vector component width
   localparam int ZW            = 25;               // angle width, 2^-16 degree
   localparam int QW            = FRAC + 2;         // clamped sine product width
   localparam int VW            = 2 * FRAC + 1;     // square root radicand width
   localparam int EXW           = $clog2(VW);       // radicand bit exponent width
   localparam int SHW           = 5;                // cell shift index width
   localparam int LAT           = 2 * CORDIC_STAGES + FRAC + 8;

   // Hundredths to angle units: n * 16384 / 25 through a reciprocal
   localparam int PW            = 43;
   localparam logic [28:0] RECIP_M = 29'd343597384;
   localparam int RECIP_SH      = 19;

   // Rotation start value, CORDIC gain folded in
   localparam longint X0_L = (longint'(652032874) + ((longint'(1) << (30 - FRAC)) >>> 1))
                             >>> (30 - FRAC);
   localparam logic signed [XW-1:0] X0 = XW'(X0_L);

   localparam logic signed [2*XW-1:0] ONE_P  = (2*XW)'(longint'(1) << FRAC);
   localparam logic signed [2*QW-1:0] ONE_SQ = (2*QW)'(longint'(1) << (2 * FRAC));

   // Configuration register indexes
   localparam logic [1:0] CSR_MIN_ELEVATION = 2'd0;
   localparam logic [1:0] CSR_ZENITH_MARGIN = 2'd1;

   // Result word, first field in the high bits
   typedef struct packed {
      logic signed [14:0] y_angle;
      logic signed [14:0] x_angle;
   } result_type;

   // Side data carried along the rotation chains
   typedef struct packed {
      logic neg;
      logic zen;
   } rot_side_type;

   // Side data carried along the square root chain
   typedef struct packed {
      logic                   zen;
      logic signed [QW-1:0]   q;
      logic signed [XW-1:0]   sel;
      logic signed [XW-1:0]   p;
   } sq_side_type;

   // Side data carried along the vectoring chains
   typedef struct packed {
      logic zen;
      logic zx;
      logic zy;
   } vec_side_type;

   // atan(2^-i) in degrees times 65536
   function automatic logic signed [ZW-1:0] atan_entry(input logic [SHW-1:0] idx);
      int unsigned v;
      unique case (idx)
         5'd0:  v = 2949120;
         5'd1:  v = 1740967;
         5'd2:  v = 919879;
         5'd3:  v = 466945;
         5'd4:  v = 234379;
         5'd5:  v = 117304;
         5'd6:  v = 58666;
         5'd7:  v = 29335;
         5'd8:  v = 14668;
         5'd9:  v = 7334;
         5'd10: v = 3667;
         5'd11: v = 1833;
         5'd12: v = 917;
         5'd13: v = 458;
         5'd14: v = 229;
         5'd15: v = 115;
         5'd16: v = 57;
         5'd17: v = 29;
         5'd18: v = 14;
         5'd19: v = 7;
         5'd20: v = 4;
         5'd21: v = 2;
         5'd22: v = 1;
         default: v = 0;
      endcase
      return ZW'(v);
   endfunction

   // Angle units to hundredths, round half away from zero, saturate to 90 degrees
   function automatic logic signed [14:0] to_hund(input logic signed [ZW-1:0] z);
      logic [ZW-1:0]  mag;
      logic [ZW+6:0]  t;
      logic [ZW-10:0] r;
      logic [14:0]    s;
      mag = (z < 0) ? ZW'(-z) : ZW'(z);
      t   = (ZW+7)'(mag) * (ZW+7)'(100) + (ZW+7)'(32768);
      r   = t[ZW+6:16];
      s   = (r > (ZW-9)'(9000)) ? 15'd9000 : 15'(r);
      return (z < 0) ? 15'(-s) : s;
   endfunction

endpackage

@@ sv/az_el_to_xy_mount_top.sv @@
// Top level of the azimuth/elevation to X-Y mount angle converter.
//
// Usage:
//   req_* carries one pointing word per beat: azimuth and elevation in
//   hundredths of a degree. rsp_* returns one word per request, x_angle and
//   y_angle in signed hundredths of a degree, in request order.
//   csr_* writes min_elevation (index 0) and zenith_margin (index 1); it is
//   always ready and unknown indexes are dropped.
// Throughput: one word per cycle unless the full output buffer holds the
//   pipeline. Every step is a register stage: input reduction, folding,
//   reciprocal multiply, two rotation CORDIC chains, products, the square
//   root cell row and two vectoring CORDIC chains.
// Reset clears all valid flags and loads min_elevation = 10 and
//   zenith_margin = 1; nothing needs a clearing pass.
// When the receiver stalls, results collect in a two-word output buffer;
//   once it is full the whole pipeline holds and req_tready drops.
`include "assert_macros.svh"

module az_el_to_xy_mount_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [15:0] azimuth, [29:16] elevation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [14:0] x_angle, [29:15] y_angle
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_wdata
);

   localparam int S  = azel_pkg::CORDIC_STAGES;
   localparam int F  = azel_pkg::FRAC;
   localparam int XW = azel_pkg::XW;
   localparam int ZW = azel_pkg::ZW;
   localparam int QW = azel_pkg::QW;
   localparam int VW = azel_pkg::VW;
   localparam int PW = azel_pkg::PW;
   localparam int L  = azel_pkg::LAT;

   logic advance, accept, push;
   logic [L-1:0] vld_ff;

   // Configuration registers
   logic [13:0] min_el_ff;
   logic [9:0]  zen_mgn_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_el_ff  <= 14'd10;
         zen_mgn_ff <= 10'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            azel_pkg::CSR_MIN_ELEVATION: min_el_ff  <= csr_wdata;
            azel_pkg::CSR_ZENITH_MARGIN: zen_mgn_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   // Valid flags shift with the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[L-2:0], accept};
      end
   end

   // Stage 0: reduce azimuth, apply elevation floor and wrap, zenith test
   logic [15:0] az_raw, az0_in, az0_ff;
   logic [13:0] el_raw, el_flr, el0_in, el0_ff;
   logic        zen0_in, zen0_ff;

   always_comb begin
      az_raw  = req_tdata[15:0];
      el_raw  = req_tdata[29:16];
      az0_in  = (az_raw >= 16'd36000) ? az_raw - 16'd36000 : az_raw;
      el_flr  = (el_raw < min_el_ff) ? min_el_ff : el_raw;
      el0_in  = (el_flr >= 14'd9100) ? el_flr - 14'd9100 : el_flr;
      zen0_in = ({1'b0, el0_in} + {5'd0, zen_mgn_ff}) >= 15'd9000;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         az0_ff  <= az0_in;
         el0_ff  <= el0_in;
         zen0_ff <= zen0_in;
      end
   end

   // Stage 1: fold azimuth into +-90 degrees, split sign and magnitude
   logic signed [16:0] az_s, az_f;
   logic               neg1_in, neg1_ff, sgn1_ff, zen1_ff;
   logic [13:0]        azm1_in, azm1_ff, elm1_ff;

   always_comb begin
      az_s    = (az0_ff > 16'd18000) ? 17'sd0 + $signed({1'b0, az0_ff}) - 17'sd36000
                                     : $signed({1'b0, az0_ff});
      az_f    = az_s;
      neg1_in = 1'b0;
      if (az_s > 17'sd9000) begin
         az_f    = az_s - 17'sd18000;
         neg1_in = 1'b1;
      end else if (az_s < -17'sd9000) begin
         az_f    = az_s + 17'sd18000;
         neg1_in = 1'b1;
      end
      azm1_in = (az_f < 0) ? 14'(-az_f) : 14'(az_f);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         azm1_ff <= azm1_in;
         sgn1_ff <= az_f[16];
         neg1_ff <= neg1_in;
         elm1_ff <= el0_ff;
         zen1_ff <= zen0_ff;
      end
   end

   // Stage 2: hundredths to angle units by reciprocal multiply
   logic [PW-1:0] azp2_ff, elp2_ff;
   logic          sgn2_ff;
   azel_pkg::rot_side_type rside [0:S];

   always_ff @(posedge clock) begin
      if (advance) begin
         azp2_ff       <= PW'(azm1_ff) * PW'(azel_pkg::RECIP_M);
         elp2_ff       <= PW'(elm1_ff) * PW'(azel_pkg::RECIP_M);
         sgn2_ff       <= sgn1_ff;
         rside[0].neg  <= neg1_ff;
         rside[0].zen  <= zen1_ff;
      end
   end

   // Rotation chains for azimuth and elevation
   logic signed [XW-1:0] rxa [0:S];
   logic signed [XW-1:0] rya [0:S];
   logic signed [ZW-1:0] rza [0:S];
   logic signed [XW-1:0] rxe [0:S];
   logic signed [XW-1:0] rye [0:S];
   logic signed [ZW-1:0] rze [0:S];
   logic signed [ZW-1:0] az_mag_z, el_mag_z;

   always_comb begin
      az_mag_z = ZW'(azp2_ff[PW-1:azel_pkg::RECIP_SH]);
      el_mag_z = ZW'(elp2_ff[PW-1:azel_pkg::RECIP_SH]);
      rxa[0]   = azel_pkg::X0;
      rya[0]   = '0;
      rza[0]   = sgn2_ff ? -az_mag_z : az_mag_z;
      rxe[0]   = azel_pkg::X0;
      rye[0]   = '0;
      rze[0]   = el_mag_z;
   end

   for (genvar k = 0; k < S; k++) begin : g_rot
      azel_rot_cell u_az (
         .clock (clock), .en (advance), .shift (azel_pkg::SHW'(k)),
         .src_x (rxa[k]), .src_y (rya[k]), .src_z (rza[k]),
         .x_out (rxa[k+1]), .y_out (rya[k+1]), .z_out (rza[k+1])
      );
      azel_rot_cell u_el (
         .clock (clock), .en (advance), .shift (azel_pkg::SHW'(k)),
         .src_x (rxe[k]), .src_y (rye[k]), .src_z (rze[k]),
         .x_out (rxe[k+1]), .y_out (rye[k+1]), .z_out (rze[k+1])
      );
      always_ff @(posedge clock) begin
         if (advance) begin
            rside[k+1] <= rside[k];
         end
      end
   end

   // P1: products cos az * cos el and sin az * cos el
   logic signed [XW-1:0]   caz, saz, sel1_in, sel1_ff;
   logic signed [2*XW-1:0] pp_in, pp_ff, qq_in, qq_ff;
   logic                   zenp1_ff;

   always_comb begin
      caz     = rside[S].neg ? -rxa[S] : rxa[S];
      saz     = rside[S].neg ? -rya[S] : rya[S];
      pp_in   = caz * rxe[S];
      qq_in   = saz * rxe[S];
      sel1_in = (rye[S] < 0) ? '0 : rye[S];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pp_ff    <= pp_in;
         qq_ff    <= qq_in;
         sel1_ff  <= sel1_in;
         zenp1_ff <= rside[S].zen;
      end
   end

   // P2: scale products, clamp the sine term to +-1
   logic signed [2*XW-1:0] qs;
   logic signed [XW-1:0]   p2_ff, sel2_ff;
   logic signed [QW-1:0]   q2_in, q2_ff;
   logic                   zenp2_ff;

   always_comb begin
      qs = qq_ff >>> F;
      if (qs > azel_pkg::ONE_P) begin
         q2_in = QW'(azel_pkg::ONE_P);
      end else if (qs < -azel_pkg::ONE_P) begin
         q2_in = QW'(-azel_pkg::ONE_P);
      end else begin
         q2_in = QW'(qs);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p2_ff    <= XW'(pp_ff >>> F);
         q2_ff    <= q2_in;
         sel2_ff  <= sel1_ff;
         zenp2_ff <= zenp1_ff;
      end
   end

   // P3: square the sine term
   logic signed [2*QW-1:0] sq_ff;
   azel_pkg::sq_side_type  sside [0:F+1];

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff         <= q2_ff * q2_ff;
         sside[0].zen  <= zenp2_ff;
         sside[0].q    <= q2_ff;
         sside[0].sel  <= sel2_ff;
         sside[0].p    <= p2_ff;
      end
   end

   // Square root row: c = sqrt(1 - q^2)
   logic [VW-1:0] sv [0:F+1];
   logic [VW-1:0] sr [0:F+1];

   assign sv[0] = VW'(azel_pkg::ONE_SQ - sq_ff);
   assign sr[0] = '0;

   for (genvar k = 0; k <= F; k++) begin : g_sqrt
      azel_sqrt_cell u_cell (
         .clock (clock), .en (advance), .expo (azel_pkg::EXW'(2 * (F - k))),
         .src_v (sv[k]), .src_r (sr[k]), .v_out (sv[k+1]), .r_out (sr[k+1])
      );
      always_ff @(posedge clock) begin
         if (advance) begin
            sside[k+1] <= sside[k];
         end
      end
   end

   // Vectoring chains: atan2 for X and for Y
   logic signed [XW-1:0] vx [0:S];
   logic signed [XW-1:0] vy [0:S];
   logic signed [ZW-1:0] vz [0:S];
   logic signed [XW-1:0] wx [0:S];
   logic signed [XW-1:0] wy [0:S];
   logic signed [ZW-1:0] wz [0:S];
   azel_pkg::vec_side_type vside [0:S];

   always_comb begin
      vx[0]     = sside[F+1].sel;
      vy[0]     = sside[F+1].p;
      vz[0]     = '0;
      wx[0]     = XW'(sr[F+1][F:0]);
      wy[0]     = XW'(sside[F+1].q);
      wz[0]     = '0;
      vside[0].zen = sside[F+1].zen;
      vside[0].zx  = (sside[F+1].sel == 0) && (sside[F+1].p == 0);
      vside[0].zy  = (sr[F+1] == 0) && (sside[F+1].q == 0);
   end

   for (genvar k = 0; k < S; k++) begin : g_vec
      azel_vec_cell u_x (
         .clock (clock), .en (advance), .shift (azel_pkg::SHW'(k)),
         .src_x (vx[k]), .src_y (vy[k]), .src_z (vz[k]),
         .x_out (vx[k+1]), .y_out (vy[k+1]), .z_out (vz[k+1])
      );
      azel_vec_cell u_y (
         .clock (clock), .en (advance), .shift (azel_pkg::SHW'(k)),
         .src_x (wx[k]), .src_y (wy[k]), .src_z (wz[k]),
         .x_out (wx[k+1]), .y_out (wy[k+1]), .z_out (wz[k+1])
      );
      always_ff @(posedge clock) begin
         if (advance) begin
            vside[k+1] <= vside[k];
         end
      end
   end

   // Final stage: back to hundredths, apply zenith and zero cases
   azel_pkg::result_type res_in, res_ff;

   always_comb begin
      res_in.x_angle = (vside[S].zen || vside[S].zx) ? 15'sd0 : azel_pkg::to_hund(vz[S]);
      res_in.y_angle = vside[S].zy ? 15'sd0 : -azel_pkg::to_hund(wz[S]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign push = advance && vld_ff[L-1];

   azel_out_buf u_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (res_ff),
      .room       (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `ASSERT_CLK(a_x_range, clock, reset, vld_ff[L-1] |-> (res_ff.x_angle <= 15'sd9000 && res_ff.x_angle >= -15'sd9000), "x_angle out of range")
   `ASSERT_CLK(a_y_range, clock, reset, vld_ff[L-1] |-> (res_ff.y_angle <= 15'sd9000 && res_ff.y_angle >= -15'sd9000), "y_angle out of range")

endmodule

@@ sv/azel_rot_cell.sv @@
// One rotation-mode CORDIC cell: turns the vector by the residual angle.
module azel_rot_cell (
   input  logic                           clock,
   input  logic                           en,
   input  logic [azel_pkg::SHW-1:0]       shift,
   input  logic signed [azel_pkg::XW-1:0] src_x,
   input  logic signed [azel_pkg::XW-1:0] src_y,
   input  logic signed [azel_pkg::ZW-1:0] src_z,
   output logic signed [azel_pkg::XW-1:0] x_out,
   output logic signed [azel_pkg::XW-1:0] y_out,
   output logic signed [azel_pkg::ZW-1:0] z_out
);

   logic signed [azel_pkg::XW-1:0] x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [azel_pkg::ZW-1:0] z_ff, z_in, ang;

   // Rotate toward zero residual angle
   always_comb begin
      dx  = src_y >>> shift;
      dy  = src_x >>> shift;
      ang = azel_pkg::atan_entry(shift);
      if (src_z >= 0) begin
         x_in = src_x - dx;
         y_in = src_y + dy;
         z_in = src_z - ang;
      end else begin
         x_in = src_x + dx;
         y_in = src_y - dy;
         z_in = src_z + ang;
      end
   end

   // Hold while stalled
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

@@ sv/azel_vec_cell.sv @@
// One vectoring-mode CORDIC cell: drives y to zero and sums the angle.
module azel_vec_cell (
   input  logic                           clock,
   input  logic                           en,
   input  logic [azel_pkg::SHW-1:0]       shift,
   input  logic signed [azel_pkg::XW-1:0] src_x,
   input  logic signed [azel_pkg::XW-1:0] src_y,
   input  logic signed [azel_pkg::ZW-1:0] src_z,
   output logic signed [azel_pkg::XW-1:0] x_out,
   output logic signed [azel_pkg::XW-1:0] y_out,
   output logic signed [azel_pkg::ZW-1:0] z_out
);

   logic signed [azel_pkg::XW-1:0] x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [azel_pkg::ZW-1:0] z_ff, z_in, ang;

   // Rotate the vector onto the x axis
   always_comb begin
      dx  = src_y >>> shift;
      dy  = src_x >>> shift;
      ang = azel_pkg::atan_entry(shift);
      if (src_y > 0) begin
         x_in = src_x + dx;
         y_in = src_y - dy;
         z_in = src_z + ang;
      end else begin
         x_in = src_x - dx;
         y_in = src_y + dy;
         z_in = src_z - ang;
      end
   end

   // Hold while stalled
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

@@ sv/azel_sqrt_cell.sv @@
// One step of the digit-by-digit integer square root, one root bit per cell.
module azel_sqrt_cell (
   input  logic                      clock,
   input  logic                      en,
   input  logic [azel_pkg::EXW-1:0]  expo,
   input  logic [azel_pkg::VW-1:0]   src_v,
   input  logic [azel_pkg::VW-1:0]   src_r,
   output logic [azel_pkg::VW-1:0]   v_out,
   output logic [azel_pkg::VW-1:0]   r_out
);

   logic [azel_pkg::VW-1:0] v_ff, v_in, r_ff, r_in, bit_w;
   logic [azel_pkg::VW:0]   trial;

   // Subtract the trial value when it fits
   always_comb begin
      bit_w = azel_pkg::VW'(1) << expo;
      trial = {1'b0, src_r} + {1'b0, bit_w};
      if ({1'b0, src_v} >= trial) begin
         v_in = src_v - trial[azel_pkg::VW-1:0];
         r_in = (src_r >> 1) + bit_w;
      end else begin
         v_in = src_v;
         r_in = src_r >> 1;
      end
   end

   // Hold while stalled
   always_ff @(posedge clock) begin
      if (en) begin
         v_ff <= v_in;
         r_ff <= r_in;
      end
   end

   assign v_out = v_ff;
   assign r_out = r_ff;

endmodule

@@ sv/azel_out_buf.sv @@
// Two-word output buffer that decouples the pipeline from a stalling receiver.
`include "assert_macros.svh"

module azel_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  azel_pkg::result_type push_data,
   output logic                 room,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata    // [14:0] x_angle, [29:15] y_angle
);

   azel_pkg::result_type mem_ff [0:1];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign room       = (cnt_ff != 2'd2);
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {2'b00, mem_ff[rd_ff]};

   // Advance pointers and count
   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the incoming word
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   `ASSERT_NEVER(a_no_overflow, clock, reset, push && (cnt_ff == 2'd2), "push into full buffer")
   `ASSERT_CLK(a_pop_count, clock, reset, (pop && !push) |=> (cnt_ff == $past(cnt_ff) - 2'd1), "count did not drop on pop")

endmodule

@@ bench/tb_az_el_to_xy_mount_top.sv @@
// Self-checking bench for the az/el to X-Y mount converter with its own fixed-point predictor.
`timescale 1ns / 1ps

module tb_az_el_to_xy_mount_top;

   localparam logic [1:0] CSR_SPARE = 2'd3;   // unmapped index, must be dropped
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_WAIT = 2 * azel_pkg::CORDIC_STAGES + azel_pkg::FRAC + 20;

   // Predicts mount angles and holds the expected result words in order
   class mount_scoreboard;
      longint min_el = 10;
      longint margin = 1;
      azel_pkg::result_type angles_q[$];
      int mismatches = 0;

      function longint shr(longint v, int s);
         return v >>> s;
      endfunction

      function void rotate(longint hund, output longint c, output longint s);
         longint x, y, z, dx, dy;
         x = (longint'(652032874) + ((longint'(1) << (30 - azel_pkg::FRAC)) >>> 1))
             >>> (30 - azel_pkg::FRAC);
         y = 0;
         z = (hund * 65536) / 100;
         for (int i = 0; i < azel_pkg::CORDIC_STAGES && i < 24; i++) begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (z >= 0) begin
               x -= dx; y += dy; z -= longint'(azel_pkg::atan_entry(5'(i)));
            end else begin
               x += dx; y -= dy; z += longint'(azel_pkg::atan_entry(5'(i)));
            end
         end
         c = x;
         s = y;
      endfunction

      function longint vector_angle(longint xv, longint yv);
         longint x, y, z, dx, dy;
         x = xv; y = yv; z = 0;
         if (x == 0 && y == 0) return 0;
         for (int i = 0; i < azel_pkg::CORDIC_STAGES && i < 24; i++) begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (y > 0) begin
               x += dx; y -= dy; z += longint'(azel_pkg::atan_entry(5'(i)));
            end else begin
               x -= dx; y += dy; z -= longint'(azel_pkg::atan_entry(5'(i)));
            end
         end
         return z;
      endfunction

      function longint hund_of(longint z);
         longint r;
         if (z >= 0) r = (z * 100 + 32768) / 65536;
         else r = -((-z * 100 + 32768) / 65536);
         if (r > 9000) r = 9000;
         if (r < -9000) r = -9000;
         return r;
      endfunction

      function longint root(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = longint'(1) << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b; r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
         end
         return longint'(r);
      endfunction

      // Work out the mount angles of one accepted pointing word
      function void note(logic [15:0] az_in, logic [13:0] el_in);
         longint az, el, caz, saz, cel, sel, p, q, one, c, xo, yo;
         bit flip;
         azel_pkg::result_type r;
         flip = 0;
         az = longint'(az_in) % 36000;
         el = longint'(el_in);
         if (el < min_el) el = min_el;
         el = el % 9100;
         if (az > 18000) az -= 36000;
         if (az > 9000) begin
            az -= 18000; flip = 1;
         end else if (az < -9000) begin
            az += 18000; flip = 1;
         end
         rotate(az, caz, saz);
         if (flip) begin
            caz = -caz; saz = -saz;
         end
         rotate(el, cel, sel);
         p = (caz * cel) >>> azel_pkg::FRAC;
         q = (saz * cel) >>> azel_pkg::FRAC;
         if (el >= 9000 - margin) xo = 0;
         else begin
            if (sel < 0) sel = 0;
            xo = hund_of(vector_angle(sel, p));
         end
         one = longint'(1) << azel_pkg::FRAC;
         if (q > one) q = one;
         if (q < -one) q = -one;
         c = root(longint'(one * one - q * q));
         yo = -hund_of(vector_angle(c, q));
         r.x_angle = 15'(xo);
         r.y_angle = 15'(yo);
         angles_q.push_back(r);
      endfunction

      // Compare one result word with the oldest prediction
      function void check(logic [31:0] word);
         azel_pkg::result_type got, want;
         got = azel_pkg::result_type'(word[29:0]);
         if (angles_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result x=%0d y=%0d",
                                           got.x_angle, got.y_angle);
            return;
         end
         want = angles_q.pop_front();
         if (got.x_angle !== want.x_angle || got.y_angle !== want.y_angle) begin
            mismatches++;
            if (mismatches <= 10)
               $display("angle mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                        want.x_angle, want.y_angle, got.x_angle, got.y_angle);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [13:0] csr_wdata = '0;

   mount_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   logic hold_off = 0;
   bit pressure_go = 0;
   int quiet_cycles = 0;

   // Per-phase settings
   logic [13:0] floor_vals[4] = '{14'd0, 14'd9000, 14'd0, 14'd10};
   logic [9:0]  margin_vals[4] = '{10'd0, 10'd1000, 10'd0, 10'd1};
   int idle_vals[4]  = '{0, 75, 0, 35};
   int stall_vals[4] = '{0, 0, 75, 35};

   az_el_to_xy_mount_top u_top (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // Randomly stall the receiver, or hold it off entirely during pressure
   always @(posedge clock)
      rsp_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

   // Long receiver hold-off while the sender keeps offering words
   initial begin
      wait (pressure_go);
      @(posedge clock);
      hold_off <= 1;
      repeat (400) @(posedge clock);
      hold_off <= 0;
   end

   // Check results and watch for a stuck pipeline
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check(rsp_tdata);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("az_el_to_xy_mount_top verification failed");
            $finish;
         end
      end
   end

   task automatic send_word(logic [15:0] az, logic [13:0] el);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {2'b00, el, az};
      do @(posedge clock); while (!req_tready);
      sb.note(az, el);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [13:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == azel_pkg::CSR_MIN_ELEVATION) sb.min_el = val;
      else if (idx == azel_pkg::CSR_ZENITH_MARGIN) sb.margin = val & 14'h3FF;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.angles_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Mostly legal pointing words, with zenith probes and out-of-range elevations
   task automatic send_random();
      logic [13:0] el;
      int pick;
      pick = $urandom_range(99);
      if (pick < 75) el = 14'($urandom_range(0, 9099));
      else if (pick < 90) el = 14'($urandom_range(8980 - sb.margin, 9099));
      else el = 14'($urandom_range(0, 16383));
      send_word(16'($urandom_range(0, 65535)), el);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed corners under reset settings
      send_word(16'd0, 14'd0);
      send_word(16'd35999, 14'd9099);
      send_word(16'd36000, 14'd9000);
      send_word(16'd65535, 14'd8999);
      send_word(16'd9000, 14'd9);
      send_word(16'd9001, 14'd10);
      send_word(16'd18000, 14'd4500);
      send_word(16'd17999, 14'd16383);
      send_word(16'd27000, 14'd9100);
      send_word(16'd27001, 14'd1);
      send_word(16'd26999, 14'd8192);
      send_word(16'd18001, 14'd3000);
      send_word(16'd4500, 14'd0);
      send_word(16'd31500, 14'd9098);
      send_word(16'hAAAA, 14'h1555);
      send_word(16'h5555, 14'h2AAA);
      drain();
      csr_write(CSR_SPARE, 14'h3FFF);
      send_word(16'd9000, 14'd0);
      send_word(16'd27000, 14'd9099);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         csr_write(azel_pkg::CSR_MIN_ELEVATION,
                   ph == 2 ? 14'($urandom_range(0, 9000)) : floor_vals[ph]);
         csr_write(azel_pkg::CSR_ZENITH_MARGIN,
                   ph == 2 ? 14'($urandom_range(0, 1000)) : 14'(margin_vals[ph]));
         send_idle_pct  = idle_vals[ph];
         recv_stall_pct = stall_vals[ph];
         if (ph == 0) pressure_go = 1;
         repeat (260) send_random();
         drain();
      end

      if (sb.mismatches == 0 && sb.angles_q.size() == 0)
         $display("az_el_to_xy_mount_top verification clean");
      else
         $display("az_el_to_xy_mount_top verification failed");
      $finish;
   end

endmodule
